>>> src/frm_pkg.sv
// shared constants and types for the frame rms meter
`timescale 1ns / 1ps
`default_nettype none

package frm_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int MAG_W           = 16;
  localparam int SQ_W            = 2 * MAG_W;
  localparam int SUM_W           = 43;
  // count field of a frame record, wide enough for the largest frame limit
  localparam int CNT_W           = 17;
  localparam int COUNT_OUT_W     = 13;
  localparam int RMS_W           = 16;
  // root works on the quotient padded to an even number of bits
  localparam int X_W             = SUM_W + 1;
  localparam int ROOT_W          = X_W / 2;

  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } frame_t;

endpackage

`default_nettype wire

>>> src/frame_rms_meter.sv
// top level of the frame rms meter
//
//   port group                         dir  role
//   in_valid_i / in_ready_o            in   sample_i, last_i: one sample per transfer
//   out_valid_o / out_ready_i          out  rms_o, sample_count_o, overflow_o per frame
//
// samples are taken one per cycle unless stalled; each is squared, registered and summed
// a frame's mean and root are formed in the serial divide and root unit
// up to QUEUE_DEPTH finished frames wait for that unit; input stalls only when the queue
// is full and a frame end is pending, and the unit holds its result until it is taken
// reset clears the accumulators, the queue and the result valid
`timescale 1ns / 1ps
`default_nettype none

module frame_rms_meter #(
  parameter int MAX_SAMPLES = frm_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = frm_pkg::DEF_SAMPLE_BITS,
  parameter int QUEUE_DEPTH = frm_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [frm_pkg::SAMPLE_W-1:0]        sample_i,
  input  wire logic                                last_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  output logic [frm_pkg::RMS_W-1:0]                rms_o,
  output logic [frm_pkg::COUNT_OUT_W-1:0]          sample_count_o,
  output logic                                     overflow_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i
);

  logic            push, full, pop, q_valid;
  frm_pkg::frame_t push_frame, head_frame;

  frm_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .last_i   (last_i),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .push_o   (push),
    .frame_o  (push_frame),
    .full_i   (full)
  );

  frm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_frame)
  );

  frm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_i        (head_frame),
    .valid_i        (q_valid),
    .pop_o          (pop),
    .rms_o          (rms_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i)
  );

endmodule

`default_nettype wire

>>> src/frm_front.sv
// front end: sample intake, squaring and per-frame accumulation
`timescale 1ns / 1ps
`default_nettype none

module frm_front #(
  parameter int MAX_SAMPLES = frm_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = frm_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [frm_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic                          last_i,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  output logic                               push_o,
  output frm_pkg::frame_t                    frame_o,
  input  wire logic                          full_i
);

  localparam int CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int SbEff = (SAMPLE_BITS < frm_pkg::SAMPLE_W) ? SAMPLE_BITS : frm_pkg::SAMPLE_W;
  localparam logic [frm_pkg::MAG_W-1:0] Mask =
    frm_pkg::MAG_W'((33'd1 << SbEff) - 33'd1);
  // wider samples than the port carries are never negative
  localparam bit HasSign = (SAMPLE_BITS <= frm_pkg::SAMPLE_W);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);

  logic [frm_pkg::MAG_W-1:0] v, mag;
  logic                      neg;
  logic [frm_pkg::SQ_W-1:0]  sq;

  logic                      p_vld_q;
  logic [frm_pkg::SQ_W-1:0]  p_sq_q;
  logic                      p_last_q;

  logic [frm_pkg::SUM_W-1:0] sum_q, sum_n, sum_sat;
  logic [frm_pkg::SUM_W:0]   sum_add;
  logic [CntW-1:0]           cnt_q, cnt_n;
  logic                      ovf_q, ovf_n;
  logic                      room, advance, accept;

  assign v   = sample_i & Mask;
  assign neg = HasSign && v[SbEff-1];
  assign mag = neg ? ((~v + 16'd1) & Mask) : v;
  assign sq  = frm_pkg::SQ_W'(mag) * frm_pkg::SQ_W'(mag);

  // a frame end waits in the stage until the queue has room
  assign advance = p_vld_q && (!p_last_q || !full_i);
  assign ready_o = !p_vld_q || advance;
  assign accept  = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (accept) begin
      p_vld_q <= 1'b1;
    end else if (advance) begin
      p_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_sq_q   <= sq;
      p_last_q <= last_i;
    end
  end

  assign room    = cnt_q < MaxCnt;
  assign sum_add = {1'b0, sum_q} + (frm_pkg::SUM_W + 1)'(p_sq_q);
  assign sum_sat = sum_add[frm_pkg::SUM_W] ? '1 : sum_add[frm_pkg::SUM_W-1:0];
  assign sum_n   = room ? sum_sat : sum_q;
  assign cnt_n   = room ? CntW'(cnt_q + 1'b1) : cnt_q;
  assign ovf_n   = ovf_q | !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (advance) begin
      if (p_last_q) begin
        sum_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        sum_q <= sum_n;
        cnt_q <= cnt_n;
        ovf_q <= ovf_n;
      end
    end
  end

  assign push_o           = advance && p_last_q;
  assign frame_o.sum      = sum_n;
  assign frame_o.count    = frm_pkg::CNT_W'(cnt_n);
  assign frame_o.overflow = ovf_n;

endmodule

`default_nettype wire

>>> src/frm_queue.sv
// short queue of finished frame totals between front and back
`timescale 1ns / 1ps
`default_nettype none

module frm_queue #(
  parameter int DEPTH = frm_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire frm_pkg::frame_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output frm_pkg::frame_t      data_o
);

  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FillW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(DEPTH - 1);
  localparam logic [FillW-1:0] FullCnt = FillW'(DEPTH);

  frm_pkg::frame_t  entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = fill_q == FullCnt;
  assign valid_o = fill_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        fill_q <= FillW'(fill_q + 1'b1);
      end else if (do_pop && !do_push) begin
        fill_q <= FillW'(fill_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/frm_back.sv
// back end: serial divide of the sum by the count, then bitwise square root
`timescale 1ns / 1ps
`default_nettype none

module frm_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire frm_pkg::frame_t                  frame_i,
  input  wire logic                             valid_i,
  output logic                                  pop_o,
  output logic [frm_pkg::RMS_W-1:0]             rms_o,
  output logic [frm_pkg::COUNT_OUT_W-1:0]       sample_count_o,
  output logic                                  overflow_o,
  output logic                                  valid_o,
  input  wire logic                             ready_i
);

  localparam int SumW  = frm_pkg::SUM_W;
  localparam int CntW  = frm_pkg::CNT_W;
  localparam int XW    = frm_pkg::X_W;
  localparam int RootW = frm_pkg::ROOT_W;
  localparam int RW    = RootW + 2;
  localparam int StepW = $clog2(SumW);
  localparam logic [StepW-1:0] DivLast  = StepW'(SumW - 1);
  localparam logic [StepW-1:0] SqrtLast = StepW'(RootW - 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SQRT = 4'b0100,
    B_DONE = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [StepW-1:0]                    step_q, step_d;
  logic [XW-1:0]                       dq_q, dq_d;
  logic [CntW-1:0]                     rem_q, rem_d, div_q;
  logic [RW-1:0]                       r_q, r_d;
  logic [RootW-1:0]                    root_q, root_d;
  logic [frm_pkg::RMS_W-1:0]           rms_q, rms_d;
  logic [frm_pkg::COUNT_OUT_W-1:0]     cnt_q;
  logic                                ovf_q;

  logic [CntW:0]   rem_sh;
  logic            div_ge;
  logic [RW+1:0]   r_t, t_ext;
  logic            sq_ge;

  // restoring divide step, one quotient bit per cycle
  assign rem_sh = {rem_q, dq_q[SumW-1]};
  assign div_ge = rem_sh >= {1'b0, div_q};

  // root step, two radicand bits per cycle
  assign r_t   = {r_q, dq_q[XW-1:XW-2]};
  assign t_ext = (RW + 2)'({root_q, 2'b01});
  assign sq_ge = r_t >= t_ext;

  assign pop_o = (state_q == B_IDLE) && valid_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    r_d     = r_q;
    root_d  = root_q;
    rms_d   = rms_q;
    unique case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          state_d = B_DIV;
          step_d  = '0;
          dq_d    = {1'b0, frame_i.sum};
          rem_d   = '0;
        end
      end
      B_DIV: begin
        rem_d  = div_ge ? CntW'(rem_sh - {1'b0, div_q}) : rem_sh[CntW-1:0];
        dq_d   = {1'b0, dq_q[SumW-2:0], div_ge};
        step_d = StepW'(step_q + 1'b1);
        if (step_q == DivLast) begin
          state_d = B_SQRT;
          step_d  = '0;
          r_d     = '0;
          root_d  = '0;
          // an empty frame reads as zero
          if (div_q == '0) begin
            dq_d = '0;
          end
        end
      end
      B_SQRT: begin
        r_d    = sq_ge ? RW'(r_t - t_ext) : RW'(r_t);
        root_d = {root_q[RootW-2:0], sq_ge};
        dq_d   = {dq_q[XW-3:0], 2'b00};
        step_d = StepW'(step_q + 1'b1);
        if (step_q == SqrtLast) begin
          state_d = B_DONE;
          rms_d   = (|root_d[RootW-1:frm_pkg::RMS_W]) ? '1 : root_d[frm_pkg::RMS_W-1:0];
        end
      end
      B_DONE: begin
        if (ready_i) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    r_q    <= r_d;
    root_q <= root_d;
    rms_q  <= rms_d;
    if (pop_o) begin
      div_q <= frame_i.count;
      cnt_q <= frame_i.count[frm_pkg::COUNT_OUT_W-1:0];
      ovf_q <= frame_i.overflow;
    end
  end

  assign valid_o        = state_q == B_DONE;
  assign rms_o          = rms_q;
  assign sample_count_o = cnt_q;
  assign overflow_o     = ovf_q;

endmodule

`default_nettype wire

>>> sim/frame_rms_checker.sv
// scoreboard for the frame rms meter: predicts each frame result and checks the output channel
`timescale 1ns / 1ps

module frame_rms_checker #(
  parameter int MAX_SAMPLES = frm_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = frm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [frm_pkg::SAMPLE_W-1:0]        sample_i,
  input  logic                                last_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [frm_pkg::RMS_W-1:0]           rms_i,
  input  logic [frm_pkg::COUNT_OUT_W-1:0]     sample_count_i,
  input  logic                                overflow_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  output int                                  errors_o,
  output int                                  pending_o
);

  localparam logic [63:0] SumMax = (64'd1 << frm_pkg::SUM_W) - 64'd1;

  typedef struct packed {
    logic [frm_pkg::RMS_W-1:0]       rms;
    logic [frm_pkg::COUNT_OUT_W-1:0] count;
    logic                            overflow;
  } frame_result_t;

  frame_result_t expected_q[$];
  logic [63:0]   square_sum  = '0;
  logic [31:0]   frame_len   = '0;
  logic          dropped     = 1'b0;
  int            error_count = 0;

  always @(posedge clk_i) begin
    frame_result_t want;
    logic [63:0]   mag;
    logic [63:0]   mean;
    logic [63:0]   root;
    logic [63:0]   trial;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        mag = 64'(sample_i) & ((64'd1 << SAMPLE_BITS) - 64'd1);
        if (mag[SAMPLE_BITS-1]) mag = (64'd1 << SAMPLE_BITS) - mag;
        // samples past the frame limit are dropped but still flagged
        if (frame_len < MAX_SAMPLES) begin
          square_sum = (square_sum + mag * mag > SumMax) ? SumMax : square_sum + mag * mag;
          frame_len++;
        end else begin
          dropped = 1'b1;
        end
        if (last_i) begin
          mean = (frame_len != 0) ? square_sum / 64'(frame_len) : 64'd0;
          root = '0;
          for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= mean) root = trial;
          end
          want.rms      = (root > 64'hFFFF) ? '1 : root[frm_pkg::RMS_W-1:0];
          want.count    = frame_len[frm_pkg::COUNT_OUT_W-1:0];
          want.overflow = dropped;
          expected_q.push_back(want);
          square_sum = '0;
          frame_len  = '0;
          dropped    = 1'b0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected frame result: rms %0d count %0d overflow %0d",
                 rms_i, sample_count_i, overflow_i);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (rms_i !== want.rms) begin
            $error("rms: expected %0d, got %0d", want.rms, rms_i);
            error_count++;
          end
          if (sample_count_i !== want.count) begin
            $error("sample_count: expected %0d, got %0d", want.count, sample_count_i);
            error_count++;
          end
          if (overflow_i !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, overflow_i);
            error_count++;
          end
        end
      end
    end
    errors_o  <= error_count;
    pending_o <= expected_q.size();
  end

endmodule

>>> sim/frame_rms_meter_test.sv
// stimulus, watchdog and verdict for the frame rms meter
`timescale 1ns / 1ps

module frame_rms_meter_test;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 200;
  localparam int HoldCycles    = 600;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic [frm_pkg::SAMPLE_W-1:0]    sample;
  logic                            last;
  logic                            in_valid;
  logic                            in_ready;
  logic [frm_pkg::RMS_W-1:0]       rms;
  logic [frm_pkg::COUNT_OUT_W-1:0] sample_count;
  logic                            overflow;
  logic                            out_valid;
  logic                            out_ready;
  int                              errors;
  int                              pending;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_len   = 0;
  int items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_rms_meter dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_i       (sample),
    .last_i         (last),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rms_o          (rms),
    .sample_count_o (sample_count),
    .overflow_o     (overflow),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready)
  );

  frame_rms_checker rms_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_i       (sample),
    .last_i         (last),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .rms_i          (rms),
    .sample_count_i (sample_count),
    .overflow_i     (overflow),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // returns at the edge where the sample transfer happens
  task automatic send_sample(input logic [frm_pkg::SAMPLE_W-1:0] value, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    sample   <= value;
    last     <= is_last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [frm_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      1: begin
        return $urandom_range(1) ? 16'($urandom_range(15)) : -16'($urandom_range(15));
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int n = 1; n <= len; n++) send_sample(pick_sample(), n == len);
  endtask

  task automatic random_frames(input int items);
    int stop;
    stop = items_sent + items;
    // mostly short frames, now and then a longer one
    while (items_sent < stop) begin
      send_frame(($urandom_range(15) == 0) ? $urandom_range(80, 17) : $urandom_range(8, 1));
    end
  endtask

  initial begin : receiver
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $error("no transfer for %0d cycles", WatchdogLimit);
    $display("frame_rms_meter_test: errors");
    $finish;
  end

  initial begin : stimulus
    int wait_cycles;
    rst_n    <= 1'b0;
    sample   <= '0;
    last     <= 1'b0;
    in_valid <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-sample frames at the extremes
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b1);
    // short frames where the mean is floored before the root
    send_sample(16'h0003, 1'b0);
    send_sample(16'hFFFC, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0005, 1'b0);
    send_sample(16'h0005, 1'b0);
    send_sample(16'h0005, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    send_sample(16'd100, 1'b0);
    send_sample(-16'd100, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'h0000, 1'b1);

    // receiver holds off while single-sample frames keep coming, so the block backs up
    hold_len = HoldCycles;
    repeat (30) send_frame(1);

    idle_pct  = 0;
    stall_pct = 0;
    random_frames(250);
    idle_pct  = 68;
    stall_pct = 0;
    random_frames(250);
    idle_pct  = 0;
    stall_pct = 68;
    random_frames(250);
    idle_pct  = 23;
    stall_pct = 23;
    random_frames(250);

    stall_pct = 0;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < WatchdogLimit) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (pending != 0) $error("frame results never delivered: %0d", pending);
    if (errors == 0 && pending == 0) begin
      $display("frame_rms_meter_test: clean");
    end else begin
      $display("frame_rms_meter_test: errors");
    end
    $finish;
  end

endmodule
